// ===== hdl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// No dependencies.
`default_nettype none
package ffba_pkg;
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_OOM     = 2'd2;
    localparam logic [1:0] ST_BADFREE = 2'd3;
    localparam int SPLIT_TAIL = 16;
    localparam logic [20:0] MAX21 = 21'h1FFFFF;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_RD, S_SHIFT_WR, S_MARK,
        S_CO_RD, S_CO, S_CLOSE_RD, S_CLOSE_WR, S_DONE
    } ffba_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] offset;
    } ffba_result_t;
endpackage
`default_nettype wire

// ===== hdl/ffba_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/ffba_engine.sv =====
// Sequencer for the block table: search, split shift, free, and merge walk.
// Depends on ffba_pkg and ffba_ram.
`default_nettype none
module ffba_engine #(
    parameter int POOL_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic                   mode,
    input  wire logic [20:0]            request_bytes,
    input  wire logic [19:0]            payload_offset,
    output logic                        busy,
    output logic                        done,
    output ffba_pkg::ffba_result_t      result,
    output logic [25:0]                 used_total
);
    import ffba_pkg::*;

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = AW + 1;
    localparam int SW = 26;
    localparam logic [SW-1:0] POOL = SW'(POOL_BYTES);
    localparam logic [SW-1:0] HDR  = SW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

    // Entry: {free, size}. Entries at or above count are never used.
    localparam int EW = SW + 1;

    ffba_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] hit_reg, hit_next;
    logic [SW-1:0] start_reg, start_next;
    logic [SW-1:0] need_reg, need_next;
    logic [SW-1:0] tail_reg, tail_next;
    logic [SW-1:0] acc_reg, acc_next;
    logic [SW-1:0] used_reg, used_next;
    logic          mode_reg, mode_next;
    logic [19:0]   off_reg, off_next;
    logic          init_reg, init_next;
    ffba_result_t  res_reg, res_next;
    logic [EW-1:0] hold_reg, hold_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [EW-1:0] wdata, rdata;
    logic [CW-1:0] raddr_w;
    logic          r_free;
    logic [SW-1:0] r_size;
    logic [EW-1:0] rd;

    ffba_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_table (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign raddr = raddr_w[AW-1:0];
    // table reads return the pool block until entry 0 is first written
    assign rd     = init_reg ? {1'b1, POOL} : rdata;
    assign r_free = rd[EW-1];
    assign r_size = rd[SW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            used_reg  <= HDR;
            init_reg  <= 1'b1;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
            init_reg  <= init_next;
        end
        idx_reg   <= idx_next;
        hit_reg   <= hit_next;
        start_reg <= start_next;
        need_reg  <= need_next;
        tail_reg  <= tail_next;
        acc_reg   <= acc_next;
        mode_reg  <= mode_next;
        off_reg   <= off_next;
        res_reg   <= res_next;
        hold_reg  <= hold_next;
    end

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        hit_next   = hit_reg;
        start_next = start_reg;
        need_next  = need_reg;
        tail_next  = tail_reg;
        acc_next   = acc_reg;
        used_next  = used_reg;
        mode_next  = mode_reg;
        off_next   = off_reg;
        init_next  = init_reg;
        res_next   = res_reg;
        hold_next  = hold_reg;
        we         = 1'b0;
        waddr      = '0;
        wdata      = '0;
        raddr_w    = idx_reg;
        done       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    mode_next  = mode;
                    off_next   = payload_offset;
                    need_next  = (SW'(request_bytes) + HDR + SW'(7)) & ~SW'(7);
                    idx_next   = '0;
                    start_next = '0;
                    res_next   = '{status: ST_OK, offset: '0};
                    if ((!mode && request_bytes == '0) || (mode && payload_offset == '0))
                    begin
                        res_next.status = ST_NULL;
                        state_next = S_DONE;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                raddr_w = idx_reg;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (!mode_reg && r_free && r_size >= need_reg) begin
                    hit_next = idx_reg;
                    tail_next = r_size - need_reg;
                    res_next.offset = 20'(start_reg + HDR);
                    if (r_size >= need_reg + HDR + SW'(SPLIT_TAIL) && count_reg < MAXB)
                    begin
                        idx_next = count_reg - CW'(1);
                        state_next = S_SHIFT_RD;
                    end else begin
                        hold_next = {1'b0, r_size};
                        state_next = S_MARK;
                    end
                end else if (mode_reg && !r_free && 20'(start_reg + HDR) == off_reg
                             && start_reg + HDR < SW'(1) << 20) begin
                    hit_next = idx_reg;
                    hold_next = {1'b1, r_size};
                    state_next = S_MARK;
                end else if (idx_reg + CW'(1) >= count_reg) begin
                    res_next.status = mode_reg ? ST_BADFREE : ST_OOM;
                    res_next.offset = '0;
                    state_next = S_DONE;
                end else begin
                    start_next = start_reg + r_size;
                    idx_next = idx_reg + CW'(1);
                    raddr_w = idx_reg + CW'(1);
                    state_next = S_SCAN;
                end
                if (state_next == S_SCAN_RD || state_next == S_SHIFT_RD) begin
                    raddr_w = idx_next;
                end
            end
            S_SHIFT_RD: begin
                // move entry idx to idx+1, walking down to hit+1
                raddr_w = idx_reg;
                if (idx_reg == hit_reg) begin
                    we = 1'b1;
                    waddr = AW'(hit_reg + CW'(1));
                    wdata = {1'b1, tail_reg};
                    hold_next = {1'b0, need_reg};
                    count_next = count_reg + CW'(1);
                    state_next = S_MARK;
                end else begin
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                we = 1'b1;
                waddr = AW'(idx_reg + CW'(1));
                wdata = rd;
                idx_next = idx_reg - CW'(1);
                raddr_w = idx_next;
                state_next = S_SHIFT_RD;
            end
            S_MARK: begin
                we = 1'b1;
                waddr = AW'(hit_reg);
                wdata = hold_reg;
                if (hit_reg == '0) begin
                    init_next = 1'b0;
                end
                if (!mode_reg) begin
                    used_next = used_reg + hold_reg[SW-1:0];
                    state_next = S_DONE;
                end else begin
                    used_next = (used_reg >= hold_reg[SW-1:0]) ?
                                used_reg - hold_reg[SW-1:0] : '0;
                    idx_next = '0;
                    state_next = S_CO_RD;
                end
            end
            S_CO_RD: begin
                // start the merge walk: read entry 0, clear hold_reg and acc_reg
                raddr_w = '0;
                state_next = S_CO;
                hold_next = '0;
                acc_next = '0;
            end
            S_CO: begin
                // acc_reg: write pointer; idx_reg: read pointer; hold_reg: pending
                raddr_w = idx_reg + CW'(1);
                if (idx_reg == '0) begin
                    hold_next = rd;
                end else if (hold_reg[EW-1] && r_free) begin
                    hold_next = {1'b1, hold_reg[SW-1:0] + r_size};
                end else begin
                    we = 1'b1;
                    waddr = AW'(acc_reg);
                    wdata = hold_reg;
                    if (acc_reg == '0) init_next = 1'b0;
                    acc_next = acc_reg + SW'(1);
                    hold_next = rd;
                end
                idx_next = idx_reg + CW'(1);
                if (idx_reg + CW'(1) >= count_reg) begin
                    state_next = S_CLOSE_WR;
                end
            end
            S_CLOSE_WR: begin
                we = 1'b1;
                waddr = AW'(acc_reg);
                wdata = hold_next;
                if (acc_reg == '0) init_next = 1'b0;
                count_next = CW'(acc_reg + SW'(1));
                state_next = S_DONE;
            end
            S_CLOSE_RD: state_next = S_DONE;
            S_DONE: begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy       = state_reg != S_IDLE;
    assign result     = res_reg;
    assign used_total = used_reg;
endmodule
`default_nettype wire

// ===== hdl/first_fit_block_allocator_top.sv =====
// Top level of the first-fit block allocator: stream ports and result register.
// Depends on ffba_pkg and ffba_engine.
//
// channel  dir  tdata (low bit up)                                   tuser
// s_axis   in   request_bytes[20:0], payload_offset[40:21]           mode
// m_axis   out  status[1:0], result_offset[21:2], used[42:22],       -
//               free_bytes[63:43]
//
// One word at a time; a null request goes straight to the done state, and any
// other runs the search and the shift or merge walk over the table memory,
// which has one write and one read port. Reset is immediate, with no clearing
// pass. A stalled result holds the block; s_tready stays low until taken.
`default_nettype none
module first_fit_block_allocator_top #(
    parameter int POOL_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 256,
    parameter int HEADER_BYTES = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // request_bytes, payload_offset
    input  wire logic        s_tuser,  // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata   // status, result_offset, used, free
);
    import ffba_pkg::*;

    logic busy, done, mvalid_reg;
    ffba_result_t res;
    logic [25:0] used;
    logic [63:0] data_reg;
    logic [25:0] pool;
    logic [20:0] used_sat, free_sat;

    assign pool = 26'(POOL_BYTES);
    assign used_sat = (used > 26'(MAX21)) ? MAX21 : used[20:0];
    assign free_sat = (used >= pool) ? '0 :
                      ((pool - used) > 26'(MAX21)) ? MAX21 : 21'(pool - used);

    ffba_engine #(.POOL_BYTES(POOL_BYTES), .MAX_BLOCKS(MAX_BLOCKS),
                  .HEADER_BYTES(HEADER_BYTES)) u_engine (
        .aclk(aclk), .aresetn(aresetn),
        .start(s_tvalid && s_tready), .mode(s_tuser),
        .request_bytes(s_tdata[20:0]), .payload_offset(s_tdata[40:21]),
        .busy(busy), .done(done), .result(res), .used_total(used)
    );

    assign s_tready = !busy && !mvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (done) begin
            mvalid_reg <= 1'b1;
        end else if (m_tready) begin
            mvalid_reg <= 1'b0;
        end
        if (done) begin
            data_reg <= {free_sat, used_sat, res.offset, res.status};
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = data_reg;
endmodule
`default_nettype wire

// ===== hdl/ffba_checker.sv =====
// Port-level checks for the first-fit block allocator.
// Depends on first_fit_block_allocator_top (bound below).
`default_nettype none
module ffba_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata
);
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second word taken");
    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept with result pending");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_offset_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[21:2] == 20'd0)
        else $error("offset on failure");
endmodule

bind first_fit_block_allocator_top ffba_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
